@@ rtl/fwcr_pkg.sv @@
// Package for the framed wheel count receiver.
// Holds frame constants, the parser phase type and the result struct.
// No dependencies.
package fwcr_pkg;

  localparam logic [7:0] HdrFirst   = 8'hFE;
  localparam logic [7:0] HdrSecond  = 8'hFA;
  localparam logic [7:0] Trailer    = 8'hFF;
  localparam logic [2:0] PayloadLen = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HDR2  = 2'd1,
    PH_DATA  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] front_count;
    logic signed [15:0] back_count;
  } result_t;

endpackage

@@ rtl/fwcr_in_reg.sv @@
// Input register for the framed wheel count receiver.
// Holds one received byte until the parser stage takes it; uses fwcr_pkg.
module fwcr_in_reg
  import fwcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  output logic       in_stall,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

endmodule

@@ rtl/fwcr_parser.sv @@
// Frame parser for the framed wheel count receiver.
// Tracks the header, payload and trailer phases and builds the result; uses fwcr_pkg.
module fwcr_parser
  import fwcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [2:0] bytes_left, bytes_left_next;
  logic [7:0] payload [4];
  logic       store_en;
  logic [1:0] store_idx;
  logic [2:0] left_dec;

  assign store_idx = 2'(3'd0 - bytes_left);
  assign left_dec  = bytes_left - 3'd1;

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    store_en        = 1'b0;
    res.hit         = 1'b0;
    res.front_count = {payload[0], payload[1]};
    res.back_count  = {payload[2], payload[3]};
    priority if (byte_in == HdrFirst && phase == PH_HUNT) begin
      phase_next = PH_HDR2;
    end else if (byte_in == HdrSecond && phase == PH_HDR2) begin
      phase_next = PH_DATA;
    end else if (phase == PH_DATA && bytes_left != 3'd0) begin
      store_en        = 1'b1;
      bytes_left_next = left_dec;
      if (left_dec == 3'd0) begin
        phase_next = PH_TRAIL;
      end
    end else if (phase == PH_TRAIL) begin
      phase_next      = PH_HUNT;
      bytes_left_next = PayloadLen;
      res.hit         = (byte_in == Trailer);
    end else begin
      phase_next      = PH_HUNT;
      bytes_left_next = PayloadLen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= PayloadLen;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_en) begin
      payload[store_idx] <= byte_in;
    end
  end

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != 3'd0 && bytes_left <= PayloadLen)
    else $error("payload phase with an invalid byte count");

  a_trail_count_zero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> bytes_left == 3'd0)
    else $error("trailer phase with payload bytes outstanding");

  a_trail_returns: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_TRAIL |=> phase == PH_HUNT && bytes_left == PayloadLen)
    else $error("parser did not return to hunting after the trailer byte");

endmodule

@@ rtl/fwcr_out_reg.sv @@
// Result register for the framed wheel count receiver.
// Holds one decoded frame until the receiving side takes it; uses fwcr_pkg.
module fwcr_out_reg
  import fwcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  result_t            res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] front_count,
  output logic signed [15:0] back_count
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= step && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && step && res.hit) begin
      front_count <= res.front_count;
      back_count  <= res.back_count;
    end
  end

endmodule

@@ rtl/framed_wheel_count_receiver_top.sv @@
// Top level of the framed wheel count receiver.
// Instantiates fwcr_in_reg, fwcr_parser and fwcr_out_reg; uses fwcr_pkg.
//
// The receiver takes one serial byte per transaction and looks for frames of
// the form FE FA p0 p1 p2 p3 FF. For each frame with a good trailer it issues
// one output transaction carrying front_count = p0:p1 and back_count = p2:p3,
// both signed big-endian. Broken frames are dropped without output, and the
// byte that broke a frame is not taken as the start of a new one. One byte is
// accepted every clock cycle while the output is not stalled; a byte is held in the
// input register, parsed by the phase logic, and a finished frame is placed in
// the result register as its trailer byte is parsed. A stalled output transaction
// holds up input only once the single input register behind it is also full.
module framed_wheel_count_receiver_top
  import fwcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] front_count,
  output logic signed [15:0] back_count
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       ready;
  logic       step;
  result_t    res;

  assign step = held_valid && ready;

  fwcr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .rx_byte    (rx_byte),
    .in_stall   (in_stall),
    .advance    (ready),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  fwcr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (held_byte),
    .res     (res)
  );

  fwcr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .res         (res),
    .ready       (ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .front_count (front_count),
    .back_count  (back_count)
  );

endmodule
